/* hw/rtl/ikd_pkg.sv */
// ----------------------------------------------------------------------------
// ikd_pkg
// Shared types and constants of the infrared keypad decoder: gap classes,
// event kinds, key numbers and the table of remote control key codes.
// ----------------------------------------------------------------------------
package ikd_pkg;

   // Width of the interval unit register and of the elapsed time field.
   localparam int UNIT_W    = 16;
   localparam int ELAPSED_W = 17;
   localparam int CODE_W    = 32;
   localparam int KEY_W     = 4;
   localparam int KIND_W    = 3;
   localparam int COUNT_W   = 5;
   localparam int NUM_KEYS  = 12;

   localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd1000;

   // Classes of one gap between falling edges.
   typedef enum logic [1:0] {
      GAP_NONE = 2'd0,
      GAP_ZERO = 2'd1,
      GAP_ONE  = 2'd2,
      GAP_END  = 2'd3
   } gap_type;

   // Event kinds reported with every result word.
   typedef enum logic [KIND_W-1:0] {
      KIND_DIGIT   = 3'd0,
      KIND_DELETE  = 3'd1,
      KIND_ENTER   = 3'd2,
      KIND_UNKNOWN = 3'd3,
      KIND_FULL    = 3'd4,
      KIND_EMPTY   = 3'd5
   } kind_type;

   localparam logic [KEY_W-1:0] KEY_DELETE = 4'd10;
   localparam logic [KEY_W-1:0] KEY_ENTER  = 4'd11;
   localparam logic [KEY_W-1:0] KEY_NONE   = 4'd15;

   // Status of the frame decoder toward the sequencer.
   typedef struct packed {
      logic             done;
      logic [KEY_W-1:0] key;
   } frame_status_type;

   // Accumulated codes of the remote control buttons and the keys they mean.
   localparam logic [CODE_W-1:0] KEY_CODES [NUM_KEYS] = '{
      32'd2545244255, 32'd66219167,   32'd2820691487, 32'd1106806847,
      32'd3861279167, 32'd1382254079, 32'd4136726399, 32'd3358349263,
      32'd1817854287, 32'd4085739231, 32'd3633796495, 32'd891055645
   };
   localparam logic [KEY_W-1:0] KEY_VALUES [NUM_KEYS] = '{
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd0,
      KEY_DELETE, KEY_ENTER
   };

   // Look up a code in the key table; unmatched codes give KEY_NONE.
   function automatic logic [KEY_W-1:0] match_key(input logic [CODE_W-1:0] code);
      logic [KEY_W-1:0] key;
      key = KEY_NONE;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (KEY_CODES[i] == code) begin
            key = KEY_VALUES[i];
         end
      end
      return key;
   endfunction

endpackage

/* hw/rtl/ikd_digit_ram.sv */
// ----------------------------------------------------------------------------
// ikd_digit_ram
// Digit buffer memory: one write port and one read port, with the read
// data registered.
// ----------------------------------------------------------------------------
module ikd_digit_ram
   import ikd_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [KEY_W-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [KEY_W-1:0]  rd_data
);

   logic [KEY_W-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hw/rtl/ikd_frame_decoder.sv */
// ----------------------------------------------------------------------------
// ikd_frame_decoder
// Classifies each edge gap against the interval unit, accumulates the
// frame code and matches a finished code against the key table.
// ----------------------------------------------------------------------------
module ikd_frame_decoder
   import ikd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [ELAPSED_W-1:0] elapsed_us,
   input  logic [UNIT_W-1:0]    unit_us,
   output frame_status_type     frame
);

   logic [CODE_W-1:0] code_ff;
   logic [CODE_W-1:0] code_in;
   logic [CODE_W-1:0] code_x10;
   logic [UNIT_W-1:0] unit;
   logic [ELAPSED_W:0] unit1;
   logic [ELAPSED_W:0] unit2;
   logic [ELAPSED_W:0] unit3;
   logic [ELAPSED_W:0] gap;
   gap_type            gap_class;

   // A unit of zero counts as one. The gap is compared against one, two and
   // three units, which stands in for the truncating division.
   always_comb begin
      unit  = (unit_us == '0) ? UNIT_W'(1) : unit_us;
      unit1 = {2'b00, unit};
      unit2 = {1'b0, unit, 1'b0};
      unit3 = unit1 + unit2;
      gap   = {1'b0, elapsed_us};
      if (gap < unit1) begin
         gap_class = GAP_NONE;
      end else if (gap < unit2) begin
         gap_class = GAP_ZERO;
      end else if (gap < unit3) begin
         gap_class = GAP_ONE;
      end else begin
         gap_class = GAP_END;
      end
   end

   // Code accumulator: times ten plus the bit, cleared at every frame end.
   always_comb begin
      code_x10 = {code_ff[CODE_W-4:0], 3'b000} + {code_ff[CODE_W-2:0], 1'b0};
      code_in  = code_ff;
      if (step) begin
         case (gap_class)
            GAP_ZERO: code_in = code_x10;
            GAP_ONE:  code_in = code_x10 + CODE_W'(1);
            GAP_END:  code_in = '0;
            default:  code_in = code_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '0;
      end else begin
         code_ff <= code_in;
      end
   end

   // A frame with a nonzero code produces a key event.
   assign frame.done = step && (gap_class == GAP_END) && (code_ff != '0);
   assign frame.key  = match_key(code_ff);

endmodule

/* hw/rtl/ir_pulse_keypad_decoder_unit.sv */
// ----------------------------------------------------------------------------
// ir_pulse_keypad_decoder_unit
// Infrared remote keypad decoder: gap words in, key event words out.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one word per falling edge of the receiver: the
//   microseconds since the previous edge. Short gaps build up the frame code;
//   a long gap ends the frame, and a nonzero code gives one rsp word with the
//   event kind, the key, the digit count and, on enter, the buffered number.
//   Gaps that only extend a code, and frames with a zero code, give no word.
//   The csr channel writes the interval unit; it is always ready.
// Throughput:
//   One word is worked on at a time: the next gap is accepted once the last
//   one is evaluated and, at a frame end, its result is handed off. Enter
//   walks the digit memory one entry a cycle through its single read port.
// Reset:
//   Synchronous reset clears the code, empties the buffer and sets the unit
//   to 1000 us. The digit memory itself is not cleared.
// Stall:
//   A result waits in the output register while rsp_stall is high; the next
//   gap is still accepted and worked on until its own result needs the
//   output register.
// ----------------------------------------------------------------------------
module ir_pulse_keypad_decoder_unit
   import ikd_pkg::*;
#(
   parameter int MAX_DIGITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // Gap words.
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ELAPSED_W-1:0] req_elapsed_us,
   // Event words.
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [KIND_W-1:0]    rsp_event_kind,
   output logic [KEY_W-1:0]     rsp_key,
   output logic [COUNT_W-1:0]   rsp_digit_count,
   output logic signed [31:0]   rsp_number_value,
   // Interval unit register.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [UNIT_W-1:0]    csr_unit_us
);

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_WALK = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [UNIT_W-1:0]    unit_ff;
   logic [ELAPSED_W-1:0] elapsed_ff;
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     walk_ff, walk_in;
   logic [31:0]          value_ff, value_in;
   kind_type             kind_ff, kind_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]    rsp_kind_ff;
   logic [KEY_W-1:0]     rsp_key_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [31:0]          rsp_value_ff;
   logic                 rsp_load;
   logic [CNT_W+COUNT_W-1:0] total_ext;

   frame_status_type     frame;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [KEY_W-1:0]     wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [KEY_W-1:0]     rd_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   ikd_frame_decoder u_frame (
      .clock      (clock),
      .reset      (reset),
      .step       (state_ff == ST_EVAL),
      .elapsed_us (elapsed_ff),
      .unit_us    (unit_ff),
      .frame      (frame)
   );

   ikd_digit_ram #(
      .DEPTH (MAX_DIGITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: evaluate the gap, act on the key, walk the buffer on enter.
   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      walk_in  = walk_ff;
      value_in = value_ff;
      kind_in  = kind_ff;
      key_in   = key_ff;
      wr_en    = 1'b0;
      wr_addr  = total_ff[ADDR_W-1:0];
      wr_data  = frame.key;
      rd_en    = 1'b0;
      rd_addr  = walk_ff[ADDR_W-1:0];
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_IDLE;
            if (frame.done) begin
               key_in   = frame.key;
               value_in = '0;
               state_in = ST_EMIT;
               unique case (frame.key)
                  KEY_NONE: begin
                     kind_in = KIND_UNKNOWN;
                  end
                  KEY_DELETE: begin
                     if (total_ff != '0) begin
                        total_in = total_ff - CNT_W'(1);
                        kind_in  = KIND_DELETE;
                     end else begin
                        kind_in = KIND_EMPTY;
                     end
                  end
                  KEY_ENTER: begin
                     kind_in = KIND_ENTER;
                     if (total_ff == '0) begin
                        value_in = '1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        walk_in  = CNT_W'(1);
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     if (total_ff < CNT_W'(MAX_DIGITS)) begin
                        wr_en    = 1'b1;
                        total_in = total_ff + CNT_W'(1);
                        kind_in  = KIND_DIGIT;
                     end else begin
                        kind_in = KIND_FULL;
                     end
                  end
               endcase
            end
         end
         ST_WALK: begin
            // The digit read last cycle joins the running decimal value.
            value_in = {value_ff[28:0], 3'b000} + {value_ff[30:0], 1'b0}
                     + {28'd0, rd_data};
            if (walk_ff == total_ff) begin
               total_in = '0;
               state_in = ST_EMIT;
            end else begin
               rd_en   = 1'b1;
               walk_in = walk_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid holds while stalled and is set when a result is loaded.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign total_ext = {{COUNT_W{1'b0}}, total_ff};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         unit_ff      <= UNIT_RESET;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unit_ff <= csr_unit_us;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         elapsed_ff <= req_elapsed_us;
      end
      walk_ff  <= walk_in;
      value_ff <= value_in;
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      if (rsp_load) begin
         rsp_kind_ff  <= kind_ff;
         rsp_key_ff   <= key_ff;
         rsp_count_ff <= total_ext[COUNT_W-1:0];
         rsp_value_ff <= value_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_key          = rsp_key_ff;
   assign rsp_digit_count  = rsp_count_ff;
   assign rsp_number_value = rsp_value_ff;

endmodule
